### sv/usp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usp_pkg
// Shared types, constants and byte classification for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package usp_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int HELD_DEPTH      = 3;
	localparam int PKT_LANES       = 4;

	localparam logic [7:0] REPL_RESET = 8'h3F;
	localparam logic [1:0] CONT_TAG   = 2'b10;

	localparam logic [7:0] LEAD2_LO = 8'hC0;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF7;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [PKT_LANES-1:0][7:0] bytes;
		logic [2:0]                n;
		logic                      last;
	} pkt_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_NONE;
		if (b >= LEAD2_LO && b <= LEAD2_HI)
			len = LEN_TWO;
		else if (b >= LEAD3_LO && b <= LEAD3_HI)
			len = LEN_THREE;
		else if (b >= LEAD4_LO && b <= LEAD4_HI)
			len = LEN_FOUR;
		return len;
	endfunction

endpackage
`default_nettype wire

### sv/usp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usp_front
// Accepts input bytes, tracks the open sequence and builds one output packet
// of up to four bytes per item.
// ----------------------------------------------------------------------------
module usp_front
	import usp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire byte_t in_byte,
	input  wire logic  in_last,
	input  wire byte_t repl,
	input  wire logic  queue_full,
	output logic       push,
	output pkt_t       pkt
);

	logic [2:0] needed_q;
	logic [1:0] cnt_q;
	byte_t      held_q [HELD_DEPTH];

	logic [2:0] needed_d;
	logic [1:0] cnt_d;
	logic       held_wr;
	logic [1:0] held_idx;

	logic       is_cont;
	logic [2:0] len;
	logic       f_put;
	logic       f_hold;
	byte_t      f_byte;

	logic [1:0] k;
	logic       pre_held;
	logic       tail_en;
	byte_t      tail;
	logic       accept;

	assign is_cont = (in_byte[7:6] == CONT_TAG);
	assign len     = lead_len(in_byte);

	always_comb begin
		f_put  = 1'b0;
		f_hold = 1'b0;
		f_byte = repl;
		if (!in_byte[7]) begin
			f_put  = 1'b1;
			f_byte = in_byte;
		end else if (len != LEN_NONE && !in_last) begin
			f_hold = 1'b1;
		end else begin
			f_put = 1'b1;
		end
	end

	always_comb begin
		k        = 2'd0;
		pre_held = 1'b0;
		tail_en  = 1'b0;
		tail     = in_byte;
		needed_d = needed_q;
		cnt_d    = cnt_q;
		held_wr  = 1'b0;
		held_idx = 2'd0;
		if (needed_q != LEN_NONE && is_cont) begin
			if (({1'b0, cnt_q} + 3'd1) >= needed_q) begin
				k        = cnt_q;
				pre_held = 1'b1;
				tail_en  = 1'b1;
				needed_d = LEN_NONE;
				cnt_d    = 2'd0;
			end else if (in_last) begin
				k        = cnt_q;
				tail_en  = 1'b1;
				tail     = repl;
				needed_d = LEN_NONE;
				cnt_d    = 2'd0;
			end else begin
				held_wr  = 1'b1;
				held_idx = cnt_q;
				cnt_d    = cnt_q + 2'd1;
			end
		end else begin
			// flush a broken sequence, then handle the byte fresh
			if (needed_q != LEN_NONE)
				k = cnt_q;
			needed_d = LEN_NONE;
			cnt_d    = 2'd0;
			tail_en  = f_put;
			tail     = f_byte;
			if (f_hold) begin
				held_wr  = 1'b1;
				held_idx = 2'd0;
				cnt_d    = 2'd1;
				needed_d = len;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < HELD_DEPTH; i++) begin
			if (2'(i) < k)
				pkt.bytes[i] = pre_held ? held_q[i] : repl;
			else if (2'(i) == k)
				pkt.bytes[i] = tail;
			else
				pkt.bytes[i] = repl;
		end
		pkt.bytes[PKT_LANES-1] = (k == 2'd3) ? tail : repl;
		pkt.n    = {1'b0, k} + {2'b00, tail_en};
		pkt.last = in_last;
	end

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (pkt.n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= LEN_NONE;
			cnt_q    <= 2'd0;
		end else if (accept) begin
			needed_q <= needed_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_wr)
			held_q[held_idx] <= in_byte;
	end

endmodule
`default_nettype wire

### sv/usp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usp_queue
// Short packet queue between the front and the back.
// ----------------------------------------------------------------------------
module usp_queue
	import usp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire pkt_t wr_pkt,
	input  wire logic pop,
	output logic      full,
	output logic      valid,
	output pkt_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pkt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_pkt;
	end

endmodule
`default_nettype wire

### sv/usp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usp_back
// Takes packets from the queue and sends their bytes out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module usp_back
	import usp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic queue_valid,
	input  wire pkt_t head,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output byte_t     out_byte,
	output logic      out_last
);

	logic       busy_q;
	pkt_t       pkt_q;
	logic [1:0] idx_q;
	logic       end_lane;
	logic       out_acc;

	assign end_lane  = (({1'b0, idx_q} + 3'd1) == pkt_q.n);
	assign out_valid = busy_q;
	assign out_byte  = pkt_q.bytes[idx_q];
	assign out_last  = pkt_q.last && end_lane;
	assign out_acc   = busy_q && out_ready;
	assign pop       = queue_valid && (!busy_q || (out_acc && end_lane));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (out_acc) begin
			if (end_lane)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			pkt_q <= head;
	end

endmodule
`default_nettype wire

### sv/utf8_sanitizer_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_sanitizer_stream
// Streaming UTF-8 cleaner: passes well-formed sequences, replaces bad bytes.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | sink      | in_valid/in_ready   | in_byte, in_last
// out     | source    | out_valid/out_ready | out_byte, out_last
// cfg     | sink      | cfg_valid/cfg_ready | cfg_data (replacement byte)
//
// One input item per cycle while the packet queue has room; each item yields
// 0 to 4 output bytes, sent one per cycle while out_ready is high, so the
// output port sets the rate: one byte in per byte out.
// Reset clears the open sequence, the queue and the output stage; the
// replacement byte resets to 0x3F. cfg_ready is always high.
// The front stalls only when the packet queue is full.
// ----------------------------------------------------------------------------
module utf8_sanitizer_stream
	import usp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire byte_t in_byte,
	input  wire logic  in_last,
	output logic       out_valid,
	input  wire logic  out_ready,
	output byte_t      out_byte,
	output logic       out_last,
	input  wire logic  cfg_valid,
	output logic       cfg_ready,
	input  wire byte_t cfg_data
);

	byte_t repl_q;
	logic  queue_full;
	logic  queue_valid;
	logic  push;
	logic  pop;
	pkt_t  front_pkt;
	pkt_t  head_pkt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			repl_q <= REPL_RESET;
		else if (cfg_valid && cfg_ready)
			repl_q <= cfg_data;
	end

	usp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.repl       (repl_q),
		.queue_full (queue_full),
		.push       (push),
		.pkt        (front_pkt)
	);

	usp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_pkt (front_pkt),
		.pop    (pop),
		.full   (queue_full),
		.valid  (queue_valid),
		.head   (head_pkt)
	);

	usp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_valid (queue_valid),
		.head        (head_pkt),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_last    (out_last)
	);

endmodule
`default_nettype wire

### sv/usp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usp_checker
// Port-level checks for the UTF-8 sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
module usp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready
);

	logic [5:0] pend_q;
	logic [3:0] lasts_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// track bytes and string ends taken in but not yet sent out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			lasts_q <= '0;
		end else begin
			pend_q  <= pend_q + {5'd0, in_acc} - {5'd0, out_acc};
			lasts_q <= lasts_q + {3'd0, in_acc && in_last} - {3'd0, out_acc && out_last};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output item changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 6'd0)
		else $error("output item without a pending input byte");

	a_last_matched: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_last |-> lasts_q != 4'd0)
		else $error("out_last without a pending in_last");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

endmodule

bind utf8_sanitizer_stream usp_checker u_usp_checker (.*);
`default_nettype wire

### tb/sv/utf8_clean_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_clean_check
// Watches the input, output and register channels of the UTF-8 sanitizer.
// Keeps its own copy of the open sequence and the replacement byte, works out
// the cleaned bytes that each accepted input item causes and compares every
// output item, byte and last flag, with the oldest cleaned byte still owed.
// ----------------------------------------------------------------------------
module utf8_clean_check
	import usp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  in_ready,
	input  wire byte_t in_byte,
	input  wire logic  in_last,
	input  wire logic  out_valid,
	input  wire logic  out_ready,
	input  wire byte_t out_byte,
	input  wire logic  out_last,
	input  wire logic  cfg_valid,
	input  wire logic  cfg_ready,
	input  wire byte_t cfg_data,
	output int         mismatches,
	output int         owed_bytes
);

	typedef struct packed {
		byte_t data;
		logic  last;
	} clean_byte_t;

	clean_byte_t cleaned_q[$];
	clean_byte_t step_q[$];
	clean_byte_t head;
	byte_t       repl;
	byte_t       held [HELD_DEPTH];
	logic [1:0]  held_n;
	logic [2:0]  need_len;

	function automatic logic [2:0] seq_length(input byte_t b);
		casez (b)
			8'b110?_????: return LEN_TWO;
			8'b1110_????: return LEN_THREE;
			8'b1111_0???: return LEN_FOUR;
			default:      return LEN_NONE;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("t=%0t %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic emit(input byte_t b);
		clean_byte_t c;
		c.data = b;
		c.last = 1'b0;
		step_q.insert(step_q.size(), c);
	endtask

	task automatic start_fresh(input byte_t b, input logic last);
		logic [2:0] len;
		len = seq_length(b);
		if (!b[7]) begin
			emit(b);
		end else if (len != LEN_NONE && !last) begin
			held[0]  = b;
			held_n   = 2'd1;
			need_len = len;
		end else begin
			emit(repl);
		end
	endtask

	task automatic clean_byte(input byte_t b, input logic last);
		int          n;
		clean_byte_t c;
		n = held_n;
		step_q.delete();
		if (need_len != LEN_NONE) begin
			if (b[7:6] == CONT_TAG) begin
				if (n + 1 >= need_len) begin
					for (int i = 0; i < n; i++)
						emit(held[i]);
					emit(b);
					held_n   = 2'd0;
					need_len = LEN_NONE;
				end else if (last) begin
					for (int i = 0; i <= n; i++)
						emit(repl);
					held_n   = 2'd0;
					need_len = LEN_NONE;
				end else begin
					held[n] = b;
					held_n  = 2'(n + 1);
				end
			end else begin
				for (int i = 0; i < n; i++)
					emit(repl);
				held_n   = 2'd0;
				need_len = LEN_NONE;
				start_fresh(b, last);
			end
		end else begin
			held_n = 2'd0;
			start_fresh(b, last);
		end
		for (int i = 0; i < step_q.size(); i++) begin
			c = step_q[i];
			if (last && i == step_q.size() - 1)
				c.last = 1'b1;
			cleaned_q.insert(cleaned_q.size(), c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cleaned_q.delete();
			repl     = REPL_RESET;
			held_n   = 2'd0;
			need_len = LEN_NONE;
			foreach (held[i])
				held[i] = '0;
			owed_bytes <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cleaned_q.size() == 0) begin
					report_mismatch("unexpected item", out_byte, 0);
				end else begin
					head = cleaned_q.pop_front();
					if (out_byte !== head.data)
						report_mismatch("out_byte", out_byte, head.data);
					if (out_last !== head.last)
						report_mismatch("out_last", out_last, head.last);
				end
			end
			if (in_valid && in_ready)
				clean_byte(in_byte, in_last);
			if (cfg_valid && cfg_ready)
				repl = cfg_data;
			owed_bytes <= cleaned_q.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the UTF-8 sanitizer with a directed opening of boundary bytes,
// complete, broken and cut-off sequences, then random strings built mostly
// from well-formed sequences with noise mixed in, under several replacement
// bytes and with random stalls on both channels. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import usp_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	byte_t in_byte;
	logic  in_last;
	logic  out_valid;
	logic  out_ready;
	byte_t out_byte;
	logic  out_last;
	logic  cfg_valid;
	logic  cfg_ready;
	byte_t cfg_data;
	int    mismatches;
	int    owed_bytes;

	byte_t      text_q[$];
	bit         steady;
	logic [8:0] opening [25];

	utf8_sanitizer_stream u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	utf8_clean_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.owed_bytes(owed_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int r;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (r == 9 ? $urandom_range(8, 25) : $urandom_range(1, 3)) @(posedge clk);
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	task automatic send_item(input byte_t b, input logic last, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_bytes != 0) @(posedge clk);
	endtask

	task automatic write_repl(input byte_t v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_chunk();
		int    r;
		int    len;
		int    tail;
		byte_t lead;
		r   = $urandom_range(0, 99);
		len = $urandom_range(2, 4);
		case (len)
			2:       lead = LEAD2_LO + byte_t'($urandom_range(0, 31));
			3:       lead = LEAD3_LO + byte_t'($urandom_range(0, 15));
			default: lead = LEAD4_LO + byte_t'($urandom_range(0, 7));
		endcase
		if (r < 35) begin
			text_q.insert(text_q.size(), byte_t'($urandom_range(0, 127)));
		end else if (r < 88) begin
			tail = (r < 75) ? len - 1 : $urandom_range(0, len - 2);
			text_q.insert(text_q.size(), lead);
			repeat (tail)
				text_q.insert(text_q.size(), {CONT_TAG, 6'($urandom_range(0, 63))});
		end else begin
			text_q.insert(text_q.size(), byte_t'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_text();
		foreach (text_q[i]) begin
			if (!steady && $urandom_range(0, 39) == 0)
				wait_drained();
			send_item(text_q[i], i == text_q.size() - 1, pick_gap());
		end
		text_q.delete();
	endtask

	initial begin
		int sent;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_byte   <= '0;
		in_last   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		steady = 1'b0;
		opening = '{
			9'h000, 9'h07F, 9'h080, 9'h0FF, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
			9'h0F0, 9'h09F, 9'h098, 9'h180, 9'h0DF, 9'h0BF, 9'h0E2, 9'h082, 9'h0C3,
			9'h0A9, 9'h0F7, 9'h0BF, 9'h1BF, 9'h1C0, 9'h0E2, 9'h1C3
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) begin
			if (i == 8)
				wait_drained();
			send_item(opening[i][7:0], opening[i][8], pick_gap());
		end

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1:       write_repl(8'h00);
				2:       write_repl(8'hFF);
				3, 4:    write_repl(byte_t'($urandom_range(0, 255)));
				default: ;
			endcase
			steady = (phase == 2);
			sent   = 0;
			while (sent < 25) begin
				repeat ($urandom_range(1, 6))
					add_chunk();
				sent += text_q.size();
				send_text();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
